/* sv/text_console_writer_unit_assert.svh */
// Assertion macros for the text console writer.
// Each macro checks a property sampled on the rising edge of the given clock,
// held off while the active-low reset is asserted.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("text_console_writer_unit: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TCW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("text_console_writer_unit: next-cycle check failed");

`else

`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/tcw_pkg.sv */
package tcw_pkg;

  // Fixed field widths of the transaction payloads
  localparam int OP_W   = 2;
  localparam int CH_W   = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;

  // Newline character for put-at-cursor
  localparam logic [CH_W-1:0] NEWLINE_CH = 8'd10;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_PUT_AT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_ZROW,
    ST_CLEAR,
    ST_FIN
  } state_t;

endpackage

/* sv/tcw_cell_mem.sv */
module tcw_cell_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/tcw_addr_unit.sv */
module tcw_addr_unit
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int RW   = 5,
  parameter int CW   = 7,
  parameter int AW   = 11
) (
  input  logic [RW-1:0] row_i,
  input  logic [CW-1:0] col_i,
  output logic [AW-1:0] addr_o
);

  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  // Linear cell address: row * COLS + col
  logic [AW-1:0] prod;

  assign prod   = AW'(AW'(row_i) * COLS_A);
  assign addr_o = AW'(prod + AW'(col_i));

endmodule

/* sv/text_console_writer_unit.sv */
// Text console writer: a ROWS x COLS character-cell screen with a cursor.
// Input channel (in_valid/in_ready) carries one operation per transaction:
// put at cursor, put at row/col, clear, or read cell. Output channel
// (out_valid/out_ready) returns one transaction per input: the cell word for
// a read (zero otherwise) and the cursor row and column after the operation.
// Configuration: cfg_we writes cfg_wdata to the foreground (index 0) or
// background (index 1) colour register.
// Sequence: a put or put at row/col passes through the execute and finish
// states before out_valid; a read adds a state for the registered read data.
// A put that runs past the last row scrolls: one cell is copied per cycle
// through the single write port, then the bottom row is zeroed. Clear sweeps
// every cell. One operation is in work at a time; in_ready is high only while
// the sequencer is idle.
// Reset: the cursor and colours go to zero and a clearing pass zeroes the cell
// memory, with in_ready low throughout.
// Stall: a finished result sits in the output register until taken; the next
// transaction is accepted meanwhile and completes up to that register, then
// holds until out_ready frees it.
`include "text_console_writer_unit_assert.svh"

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [CLR_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [CH_W-1:0]   in_ch,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] out_cell_res,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [COL_W-1:0]  out_cursor_col
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [AW-1:0] COLS_A = AW'(COLS);
  localparam logic [AW-1:0] LAST_A = AW'(CELLS - COLS);
  localparam logic [AW-1:0] END_A  = AW'(CELLS - 1);
  localparam logic [CW:0]   COLS_N = (CW+1)'(COLS);
  localparam logic [RW:0]   ROWS_N = (RW+1)'(ROWS);

  state_t state_r, state_nxt;

  logic [CLR_W-1:0]  fg_r, bg_r;
  op_t               op_r, op_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [ROW_W-1:0]  irow_r, irow_nxt;
  logic [COL_W-1:0]  icol_r, icol_nxt;
  logic [RW-1:0]     crow_r, crow_nxt;
  logic [CW-1:0]     ccol_r, ccol_nxt;
  logic [AW-1:0]     sw_r, sw_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic              wv_r, wv_nxt;
  logic [CELL_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] out_res_r, out_res_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic [RW-1:0]     au_row;
  logic [CW-1:0]     au_col;
  logic [AW-1:0]     au_addr;

  logic              in_range;
  logic              put_nl;
  logic              put_row_adv;
  logic              put_wrap;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic              out_free;
  logic              scroll_rd;

  // Cell memory
  tcw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared row/column to address unit
  tcw_addr_unit #(
    .COLS (COLS),
    .RW   (RW),
    .CW   (CW),
    .AW   (AW)
  ) u_addr (
    .row_i  (au_row),
    .col_i  (au_col),
    .addr_o (au_addr)
  );

  // Decode the held operation
  assign in_range    = (32'(irow_r) < ROWS) && (32'(icol_r) < COLS);
  assign au_row      = (op_r == OP_PUT) ? crow_r : RW'(irow_r);
  assign au_col      = (op_r == OP_PUT) ? ccol_r : CW'(icol_r);
  assign col_inc     = {1'b0, ccol_r} + (CW+1)'(1);
  assign row_inc     = {1'b0, crow_r} + (RW+1)'(1);
  assign put_nl      = (ch_r == NEWLINE_CH);
  assign put_row_adv = put_nl || (col_inc == COLS_N);
  assign put_wrap    = put_row_adv && (row_inc == ROWS_N);
  assign out_free    = !out_valid_r || out_ready;
  assign scroll_rd   = (sw_r != LAST_A);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sw_r == END_A) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_r)
          OP_PUT:   state_nxt = put_wrap ? ST_SCROLL : ST_FIN;
          OP_CLEAR: state_nxt = ST_CLEAR;
          OP_READ:  state_nxt = ST_READ;
          default:  state_nxt = ST_FIN;
        endcase
      end
      ST_READ: begin
        state_nxt = ST_FIN;
      end
      ST_SCROLL: begin
        if (!scroll_rd) state_nxt = ST_ZROW;
      end
      ST_ZROW, ST_CLEAR: begin
        if (sw_r == END_A) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    irow_nxt      = irow_r;
    icol_nxt      = icol_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    sw_nxt        = sw_r;
    wa_nxt        = wa_r;
    wv_nxt        = 1'b0;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = sw_r;
    mem_wdata     = '0;
    mem_raddr     = au_addr;
    in_ready      = 1'b0;

    case (state_r)
      // Zero one cell per cycle
      ST_INIT, ST_CLEAR, ST_ZROW: begin
        mem_we = 1'b1;
        sw_nxt = (sw_r == END_A) ? '0 : sw_r + AW'(1);
      end
      // Capture the transaction
      ST_IDLE: begin
        in_ready = 1'b1;
        op_nxt   = op_t'(in_op);
        ch_nxt   = in_ch;
        irow_nxt = in_row;
        icol_nxt = in_col;
      end
      ST_EXEC: begin
        res_nxt = '0;
        sw_nxt  = '0;
        case (op_r)
          OP_PUT: begin
            mem_we    = !put_nl;
            mem_waddr = au_addr;
            mem_wdata = {bg_r, fg_r, ch_r};
            if (put_row_adv) begin
              ccol_nxt = '0;
              if (!put_wrap) crow_nxt = RW'(row_inc);
            end else begin
              ccol_nxt = CW'(col_inc);
            end
          end
          OP_PUT_AT: begin
            mem_we    = in_range;
            mem_waddr = au_addr;
            mem_wdata = {bg_r, fg_r, ch_r};
          end
          OP_CLEAR: begin
            crow_nxt = '0;
            ccol_nxt = '0;
          end
          default: ;
        endcase
      end
      // Take the registered read data
      ST_READ: begin
        res_nxt = in_range ? mem_rdata : '0;
      end
      // Copy each cell up one row: read ahead, write in the next cycle
      ST_SCROLL: begin
        mem_we    = wv_r;
        mem_waddr = wa_r;
        mem_wdata = mem_rdata;
        mem_raddr = sw_r + COLS_A;
        if (scroll_rd) begin
          wa_nxt = sw_r;
          wv_nxt = 1'b1;
          sw_nxt = sw_r + AW'(1);
        end
      end
      // Hand the result to the output register
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_row_nxt   = ROW_W'(crow_r);
          out_col_nxt   = COL_W'(ccol_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      crow_r      <= '0;
      ccol_r      <= '0;
      sw_r        <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      sw_r        <= sw_nxt;
      wv_r        <= wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    irow_r    <= irow_nxt;
    icol_r    <= icol_nxt;
    wa_r      <= wa_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
  end

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= '0;
      bg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_FG:  fg_r <= cfg_wdata;
        CFG_BG:  bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_res   = out_res_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  `TCW_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `TCW_ASSERT_IMP(a_cursor_in_screen, clk, rst_n, 1'b1,
                  (32'(crow_r) < ROWS) && (32'(ccol_r) < COLS))
  `TCW_ASSERT_IMP(a_write_in_memory, clk, rst_n, mem_we, mem_waddr <= END_A)
  `TCW_ASSERT_IMP(a_init_quiet, clk, rst_n, state_r == ST_INIT, !in_ready && !out_valid)

endmodule

/* tb/text_console_writer_unit_tb.sv */
module text_console_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIRECTED_LEN = 25;

  // Cursor and cell view returned for every operation
  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
  } console_view_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    int                reps;
    bit                has_exp;
    logic [CELL_W-1:0] exp_cell;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
  } directed_step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_idx = CFG_FG;
  logic [CLR_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = '0;
  logic [CH_W-1:0]   in_ch = '0;
  logic [ROW_W-1:0]  in_row = '0;
  logic [COL_W-1:0]  in_col = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CELL_W-1:0] out_cell_res;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;

  // Shadow copy of the screen, cursor and colors
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       cursor_model;
  logic [CLR_W-1:0]  fg_model;
  logic [CLR_W-1:0]  bg_model;
  console_view_t     pending_views [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int scroll_count = 0;
  int clear_count = 0;
  int filled_reads = 0;
  int error_count = 0;
  int idle_cycles = 0;

  // Hand-checked cases; colors are fg 15, bg 0 so the attribute byte is 0x0F
  directed_step_t directed_steps [DIRECTED_LEN] = '{
    '{OP_READ,   8'h00, 5'd0,  7'd0,   1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_READ,   8'h00, 5'd31, 7'd127, 1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_PUT,    8'h41, 5'd0,  7'd0,   1,  1'b1, 16'h0000, 5'd0,  7'd1},
    '{OP_PUT,    8'h00, 5'd0,  7'd0,   1,  1'b1, 16'h0000, 5'd0,  7'd2},
    '{OP_PUT,    8'hFF, 5'd31, 7'd127, 1,  1'b1, 16'h0000, 5'd0,  7'd3},
    '{OP_READ,   8'h00, 5'd0,  7'd0,   1,  1'b1, 16'h0F41, 5'd0,  7'd3},
    '{OP_READ,   8'h00, 5'd0,  7'd1,   1,  1'b1, 16'h0F00, 5'd0,  7'd3},
    '{OP_READ,   8'hFF, 5'd0,  7'd2,   1,  1'b1, 16'h0FFF, 5'd0,  7'd3},
    '{OP_PUT,    8'h0A, 5'd0,  7'd0,   1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_PUT_AT, 8'h5A, 5'd24, 7'd79,  1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_PUT_AT, 8'h77, 5'd25, 7'd0,   1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_PUT_AT, 8'h77, 5'd0,  7'd80,  1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_PUT_AT, 8'h77, 5'd31, 7'd127, 1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_READ,   8'h00, 5'd24, 7'd79,  1,  1'b1, 16'h0F5A, 5'd1,  7'd0},
    '{OP_READ,   8'h00, 5'd25, 7'd0,   1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_READ,   8'h00, 5'd0,  7'd80,  1,  1'b1, 16'h0000, 5'd1,  7'd0},
    '{OP_CLEAR,  8'hFF, 5'd31, 7'd127, 1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_READ,   8'h00, 5'd24, 7'd79,  1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_PUT_AT, 8'h42, 5'd24, 7'd0,   1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_PUT_AT, 8'h43, 5'd1,  7'd5,   1,  1'b1, 16'h0000, 5'd0,  7'd0},
    '{OP_PUT,    8'h0A, 5'd0,  7'd0,   24, 1'b0, 16'h0000, 5'd0,  7'd0},
    '{OP_PUT,    8'h0A, 5'd0,  7'd0,   1,  1'b1, 16'h0000, 5'd24, 7'd0},
    '{OP_READ,   8'h00, 5'd23, 7'd0,   1,  1'b0, 16'h0000, 5'd0,  7'd0},
    '{OP_READ,   8'h00, 5'd0,  7'd5,   1,  1'b0, 16'h0000, 5'd0,  7'd0},
    '{OP_READ,   8'h00, 5'd24, 7'd0,   1,  1'b1, 16'h0000, 5'd24, 7'd0}
  };

  text_console_writer_unit #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_ch         (in_ch),
    .in_row        (in_row),
    .in_col        (in_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_res  (out_cell_res),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow screen and return the view it produces
  function automatic console_view_t console_apply(op_t op, logic [CH_W-1:0] ch,
                                                  logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    console_view_t     v;
    logic [CELL_W-1:0] word;
    bit                on_screen;
    v = '0;
    word = {bg_model, fg_model, ch};
    on_screen = (row < ROWS) && (col < COLS);
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CH) begin
          cursor_model = (cursor_model / COLS + 1) * COLS;
        end else begin
          if (cursor_model < CELLS) screen_model[cursor_model] = word;
          cursor_model++;
        end
        // shift rows up and blank the bottom row once the cursor runs off the end
        if (cursor_model >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
          if (cursor_model >= COLS) cursor_model -= COLS;
          scroll_count++;
        end
      end
      OP_PUT_AT: begin
        if (on_screen) screen_model[row * COLS + col] = word;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
        cursor_model = 0;
        clear_count++;
      end
      default: begin
        if (on_screen) v.cell_word = screen_model[row * COLS + col];
        if (v.cell_word != '0) filled_reads++;
      end
    endcase
    v.crow = ROW_W'(cursor_model / COLS);
    v.ccol = COL_W'(cursor_model % COLS);
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    error_count++;
  endtask

  // Present one transaction, hold it until accepted, then record its expected view
  task automatic send_cmd(op_t op, logic [CH_W-1:0] ch, logic [ROW_W-1:0] row,
                          logic [COL_W-1:0] col, bit has_exp, console_view_t fixed_view);
    console_view_t v;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_ch <= ch;
    in_row <= row;
    in_col <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = console_apply(op, ch, row, col);
    pending_views.push_back(has_exp ? fixed_view : v);
    items_sent++;
  endtask

  // Drop valid and wait until every pending view has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_colors(logic [CLR_W-1:0] fg, logic [CLR_W-1:0] bg);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FG;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_idx <= CFG_BG;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    fg_model = fg;
    bg_model = bg;
  endtask

  // Mostly console-like sequences: text lines, newline runs, poke and read back
  task automatic run_traffic(int count);
    int start;
    int kind;
    int len;
    int r;
    int c;
    start = items_sent;
    while (items_sent - start < count) begin
      kind = $urandom_range(99);
      if ($urandom_range(99) < 3) settle();
      if (kind < 35) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 20);
        repeat (len) send_cmd(OP_PUT, CH_W'($urandom_range(255)),
                              ROW_W'($urandom_range(31)),
                              COL_W'($urandom_range(127)), 1'b0, '0);
        send_cmd(OP_PUT, NEWLINE_CH, ROW_W'($urandom_range(31)),
                 COL_W'($urandom_range(127)), 1'b0, '0);
      end else if (kind < 50) begin
        len = ($urandom_range(2) == 0) ? $urandom_range(20, 26) : $urandom_range(1, 6);
        repeat (len) send_cmd(OP_PUT, NEWLINE_CH, ROW_W'($urandom_range(31)),
                              COL_W'($urandom_range(127)), 1'b0, '0);
      end else if (kind < 75) begin
        r = $urandom_range(ROWS - 1);
        c = $urandom_range(COLS - 1);
        send_cmd(OP_PUT_AT, CH_W'($urandom_range(255)), ROW_W'(r), COL_W'(c), 1'b0, '0);
        if ($urandom_range(1)) send_cmd(OP_PUT, CH_W'($urandom_range(255)),
                                        ROW_W'($urandom_range(31)),
                                        COL_W'($urandom_range(127)), 1'b0, '0);
        send_cmd(OP_READ, CH_W'($urandom_range(255)), ROW_W'(r), COL_W'(c), 1'b0, '0);
      end else if (kind < 87) begin
        // read near the cursor, where text was most likely written
        repeat ($urandom_range(1, 4)) begin
          r = cursor_model / COLS;
          if ($urandom_range(1) && r > 0) r = r - 1;
          if ($urandom_range(2) == 0) r = $urandom_range(ROWS - 1);
          send_cmd(OP_READ, CH_W'($urandom_range(255)), ROW_W'(r),
                   COL_W'($urandom_range(COLS - 1)), 1'b0, '0);
        end
      end else if (kind < 89) begin
        send_cmd(OP_CLEAR, CH_W'($urandom_range(255)), ROW_W'($urandom_range(31)),
                 COL_W'($urandom_range(127)), 1'b0, '0);
      end else begin
        send_cmd(op_t'($urandom_range(3)), CH_W'($urandom_range(255)),
                 ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)), 1'b0, '0);
      end
    end
  endtask

  // Receiver: stall at the phase's rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted result with the oldest pending view
  always @(posedge clk) begin : check_results
    console_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result, cell", longint'(out_cell_res), 0);
      end else begin
        want = pending_views.pop_front();
        if (out_cell_res !== want.cell_word)
          report_mismatch("cell_res", longint'(out_cell_res), longint'(want.cell_word));
        if (out_cursor_row !== want.crow)
          report_mismatch("cursor_row", longint'(out_cursor_row), longint'(want.crow));
        if (out_cursor_col !== want.ccol)
          report_mismatch("cursor_col", longint'(out_cursor_col), longint'(want.ccol));
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_writer_unit test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    directed_step_t step;
    console_view_t  fixed_view;
    int             phase_gap [4];
    int             phase_stall [4];
    logic [CLR_W-1:0] phase_fg [4];
    logic [CLR_W-1:0] phase_bg [4];
    phase_gap = '{0, 48, 0, 17};
    phase_stall = '{0, 0, 48, 17};
    phase_fg = '{4'h0, 4'h0, CLR_W'($urandom_range(15)), 4'hF};
    phase_bg = '{4'h0, 4'hF, CLR_W'($urandom_range(15)), 4'hF};
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
    cursor_model = 0;
    fg_model = '0;
    bg_model = '0;

    // Hold reset, then wait out the clearing pass
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    set_colors(4'hF, 4'h0);
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      step = directed_steps[i];
      fixed_view = '{step.exp_cell, step.crow, step.ccol};
      repeat (step.reps) send_cmd(step.op, step.ch, step.row, step.col, step.has_exp,
                                  fixed_view);
    end
    settle();

    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      set_colors(phase_fg[p], phase_bg[p]);
      run_traffic(ITEMS_PER_PHASE);
      settle();
    end
    repeat (16) @(posedge clk);

    $display("Ran %0d operations over five color settings; %0d results checked.",
             items_sent, results_checked);
    $display("Saw %0d scrolls, %0d clears and %0d reads of written cells.",
             scroll_count, clear_count, filled_reads);
    if (error_count == 0) begin
      $display("text_console_writer_unit test passed");
    end else begin
      $display("text_console_writer_unit test failed");
    end
    $finish;
  end

endmodule
